>>> rtl/fhp_pkg.sv
// fhp_pkg: shared types and constants for the fir filter with history preload
// no dependencies; used by every module of the block
`default_nettype none

package fhp_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 14;
	localparam int NREGS     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int ACC_W     = PROD_W + 3;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = 1;
	localparam int QCNT_W    = 2;

	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_FILL   = 1'b1;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic                       command;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       saturated;
	} result_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

`default_nettype wire

>>> rtl/fir_filter_with_history_preload.sv
// fir_filter_with_history_preload: direct-form fir filter with history fill command
// depends on fhp_pkg, fhp_front, fhp_queue, fhp_back
//
// usage:
//   item channel (item_valid/item_ready/item) carries command and sample; command
//   filter runs one sample through the taps and shifts it into the history,
//   command fill loads the whole history with the sample and returns sample * dc gain
//   result channel (result_valid/result_ready/result) gives one beat per item,
//   in order: the rounded, clipped output and a saturation flag
//   cfg channel writes coef_0..coef_7 (signed q2.14) by index; always ready,
//   write only while no item is in flight
// timing:
//   one item per cycle sustained while results are taken; a result passes the fifo, then
//   the multiply, pair add, final sum and round-and-clip output registers in that order
// stall:
//   a stalled result freezes the back end; the 2-entry fifo fills up,
//   then item_ready drops until the result beat is taken
// reset:
//   arst_n clears coefficients, history, fifo and all valid flags
`default_nettype none

module fir_filter_with_history_preload #(
	parameter int TAPS = 8
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                item_valid,
	output logic                               item_ready,
	input  wire  fhp_pkg::item_t               item,
	output logic                               result_valid,
	input  wire                                result_ready,
	output fhp_pkg::result_t                   result,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [fhp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [fhp_pkg::COEF_W-1:0]         cfg_wdata
);

	localparam int EW = TAPS * fhp_pkg::SAMPLE_W;

	fhp_pkg::coef_t [fhp_pkg::NREGS-1:0]       coef_q;
	logic [TAPS-1:0][fhp_pkg::SAMPLE_W-1:0]    entry;
	logic [TAPS-1:0][fhp_pkg::SAMPLE_W-1:0]    q_head;
	logic                                      q_push;
	logic                                      q_pop;
	fhp_pkg::q_stat_t                          q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid) begin
			coef_q[cfg_index] <= cfg_wdata;
		end
	end

	fhp_front #(
		.TAPS(TAPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_stat.full),
		.push       (q_push),
		.entry      (entry)
	);

	fhp_queue #(
		.W(EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (entry),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	fhp_back #(
		.TAPS(TAPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.coefs        (coef_q),
		.q_empty      (q_stat.empty),
		.q_head       (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count == fhp_pkg::QCNT_W'(fhp_pkg::QDEPTH) && !q_pop) |-> !q_push)
		else $error("fifo written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_stat.count != '0))
		else $error("fifo read while empty");

	a_stall_holds_back: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !q_pop)
		else $error("back end drained fifo while result stalled");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.saturated) |->
		(result.filtered == 16'sh7fff || result.filtered == 16'sh8000))
		else $error("saturation flag without clipped value");
`endif

endmodule

`default_nettype wire

>>> rtl/fhp_front.sv
// fhp_front: accepts input beats, keeps the sample history and builds tap operands
// depends on fhp_pkg
`default_nettype none

module fhp_front #(
	parameter int TAPS = 8
) (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  wire                                        item_valid,
	output logic                                       item_ready,
	input  wire  fhp_pkg::item_t                       item,
	input  wire                                        q_full,
	output logic                                       push,
	output logic [TAPS-1:0][fhp_pkg::SAMPLE_W-1:0]     entry
);

	localparam int HIST = TAPS - 1;

	logic [HIST-1:0][fhp_pkg::SAMPLE_W-1:0] hist_q;
	logic                                   accept;
	logic                                   is_fill;

	assign item_ready = !q_full;
	assign accept     = item_valid && !q_full;
	assign push       = accept;
	assign is_fill    = (item.command == fhp_pkg::CMD_FILL);

	// fill gives every tap the new sample, so the back end sees sample times dc gain
	always_comb begin
		entry[0] = item.sample;
		for (int k = 1; k < TAPS; k++) begin
			entry[k] = is_fill ? item.sample : hist_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (accept) begin
			if (is_fill) begin
				for (int k = 0; k < HIST; k++) begin
					hist_q[k] <= item.sample;
				end
			end else begin
				hist_q[0] <= item.sample;
				for (int k = 1; k < HIST; k++) begin
					hist_q[k] <= hist_q[k-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/fhp_queue.sv
// fhp_queue: short fifo between front and back end
// depends on fhp_pkg
`default_nettype none

module fhp_queue #(
	parameter int W = 128
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire  [W-1:0]         push_data,
	input  wire                  pop,
	output logic [W-1:0]         head,
	output fhp_pkg::q_stat_t     stat
);

	logic [W-1:0]                     mem_q [fhp_pkg::QDEPTH];
	logic [fhp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [fhp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [fhp_pkg::QCNT_W-1:0]       count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == fhp_pkg::QCNT_W'(fhp_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + fhp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + fhp_pkg::QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + fhp_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - fhp_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/fhp_back.sv
// fhp_back: multiply, pairwise add, final sum, round and clip, output register
// depends on fhp_pkg
`default_nettype none

module fhp_back #(
	parameter int TAPS = 8
) (
	input  wire                                            clk,
	input  wire                                            arst_n,
	input  wire  fhp_pkg::coef_t [fhp_pkg::NREGS-1:0]      coefs,
	input  wire                                            q_empty,
	input  wire  [TAPS-1:0][fhp_pkg::SAMPLE_W-1:0]         q_head,
	output logic                                           pop,
	output logic                                           result_valid,
	input  wire                                            result_ready,
	output fhp_pkg::result_t                               result
);

	localparam int NP    = (TAPS + 1) / 2;
	localparam int RND_W = fhp_pkg::ACC_W + 1;

	localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (fhp_pkg::FRAC_BITS - 1);
	localparam logic signed [RND_W-1:0] MAXV = RND_W'(32767);
	localparam logic signed [RND_W-1:0] MINV = -RND_W'(32768);

	logic signed [fhp_pkg::PROD_W-1:0] prod_s1 [TAPS];
	logic signed [fhp_pkg::PAIR_W-1:0] pair_d  [NP];
	logic signed [fhp_pkg::PAIR_W-1:0] pair_s2 [NP];
	logic signed [fhp_pkg::ACC_W-1:0]  acc_d;
	logic signed [fhp_pkg::ACC_W-1:0]  acc_s3;
	logic signed [RND_W-1:0]           rnd_sum;
	logic signed [RND_W-1:0]           rnd;
	logic                              valid_s1;
	logic                              valid_s2;
	logic                              valid_s3;
	logic                              out_valid_q;
	fhp_pkg::result_t                  result_q;
	fhp_pkg::result_t                  result_d;
	logic                              advance;

	assign advance      = !out_valid_q || result_ready;
	assign pop          = advance && !q_empty;
	assign result_valid = out_valid_q;
	assign result       = result_q;

	always_comb begin
		for (int j = 0; j < NP; j++) begin
			if (2 * j + 1 < TAPS) begin
				pair_d[j] = fhp_pkg::PAIR_W'(prod_s1[2*j]) + fhp_pkg::PAIR_W'(prod_s1[2*j+1]);
			end else begin
				pair_d[j] = fhp_pkg::PAIR_W'(prod_s1[2*j]);
			end
		end
	end

	always_comb begin
		acc_d = '0;
		for (int j = 0; j < NP; j++) begin
			acc_d = acc_d + fhp_pkg::ACC_W'(pair_s2[j]);
		end
	end

	// round half up, then clip to 16 bits
	always_comb begin
		rnd_sum = RND_W'(acc_s3) + HALF;
		rnd     = rnd_sum >>> fhp_pkg::FRAC_BITS;
		if (rnd > MAXV) begin
			result_d.filtered  = 16'sh7fff;
			result_d.saturated = 1'b1;
		end else if (rnd < MINV) begin
			result_d.filtered  = 16'sh8000;
			result_d.saturated = 1'b1;
		end else begin
			result_d.filtered  = rnd[fhp_pkg::SAMPLE_W-1:0];
			result_d.saturated = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < TAPS; k++) begin
				prod_s1[k] <= $signed(q_head[k]) * coefs[k];
			end
			for (int j = 0; j < NP; j++) begin
				pair_s2[j] <= pair_d[j];
			end
			acc_s3   <= acc_d;
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

endmodule

`default_nettype wire

>>> test/fir_output_checker.sv
// fir_output_checker: watches the cfg, item and result channels of the fir filter,
// predicts every output beat from its own copy of the taps and history, and counts mismatches
// depends on fhp_pkg
module fir_output_checker #(
	parameter int TAPS = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	input  wire              item_ready,
	input  fhp_pkg::item_t   item,
	input  wire              result_valid,
	input  wire              result_ready,
	input  fhp_pkg::result_t result,
	input  wire              cfg_valid,
	input  wire              cfg_ready,
	input  wire  [fhp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [fhp_pkg::COEF_W-1:0]    cfg_wdata,
	output int               errors,
	output int               pending,
	output int               outputs_checked
);

	import fhp_pkg::*;

	localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

	coef_t                      taps [NREGS];
	logic signed [SAMPLE_W-1:0] past [TAPS-1];
	result_t                    expected_outputs [$];

	function automatic result_t round_clip(input longint acc);
		longint  r;
		result_t res;
		r = (acc + ROUND_HALF) >>> FRAC_BITS;
		res.saturated = 1'b0;
		if (r > 32767) begin
			r = 32767;
			res.saturated = 1'b1;
		end else if (r < -32768) begin
			r = -32768;
			res.saturated = 1'b1;
		end
		res.filtered = r[SAMPLE_W-1:0];
		return res;
	endfunction

	// computes one output beat and advances the history
	function automatic result_t run_filter(input item_t it);
		longint x;
		longint acc;
		longint gain;
		x    = longint'($signed(it.sample));
		acc  = 0;
		gain = 0;
		if (it.command == CMD_FILL) begin
			for (int k = 0; k < TAPS && k < NREGS; k++)
				gain += longint'($signed(taps[k]));
			for (int k = 0; k < TAPS - 1; k++)
				past[k] = it.sample;
			acc = x * gain;
		end else begin
			acc = longint'($signed(taps[0])) * x;
			for (int k = 1; k < TAPS && k < NREGS; k++)
				acc += longint'($signed(taps[k])) * longint'($signed(past[k-1]));
			for (int k = TAPS - 2; k > 0; k--)
				past[k] = past[k-1];
			past[0] = it.sample;
		end
		return round_clip(acc);
	endfunction

	task automatic report_mismatch(input string text);
		$display("mismatch at output beat %0d: %s", outputs_checked, text);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (taps[k]) taps[k] = '0;
			foreach (past[k]) past[k] = '0;
			expected_outputs.delete();
			errors          = 0;
			pending         = 0;
			outputs_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < NREGS)
				taps[cfg_index] = coef_t'(cfg_wdata);
			if (item_valid && item_ready)
				expected_outputs.push_back(run_filter(item));
			if (result_valid && result_ready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch($sformatf("output %0d/%0b with nothing expected",
						result.filtered, result.saturated));
				end else begin
					want = expected_outputs.pop_front();
					if (result.filtered !== want.filtered)
						report_mismatch($sformatf("filtered %0d, expected %0d",
							result.filtered, want.filtered));
					if (result.saturated !== want.saturated)
						report_mismatch($sformatf("saturated %0b, expected %0b",
							result.saturated, want.saturated));
				end
				outputs_checked++;
			end
			pending = expected_outputs.size();
		end
	end

endmodule

>>> test/testbench.sv
// testbench: drives directed and random samples and coefficient sets into the fir filter
// with random stalls and one long result hold-off; depends on fhp_pkg,
// fir_filter_with_history_preload and fir_output_checker
module testbench;

	import fhp_pkg::*;

	localparam int TAPS         = 8;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASE_ITEMS  = 105;
	localparam int RANDOM_PHASES = 6;

	typedef enum {PLAN_FULL, PLAN_SMALL, PLAN_EXTREME} coef_style_e;

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_ready;
	item_t                  item;
	logic                   result_valid;
	logic                   result_ready;
	result_t                result;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [COEF_W-1:0]      cfg_wdata;

	int errors;
	int pending;
	int outputs_checked;

	coef_t coef_plan [NREGS];
	bit    idle_on;
	bit    hold_req;
	int    hold_count;
	int    samples_sent;
	int    fills_sent;
	int    coef_sets;
	int    quiet_cycles;

	fir_filter_with_history_preload #(
		.TAPS(TAPS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	fir_output_checker #(
		.TAPS(TAPS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.errors         (errors),
		.pending        (pending),
		.outputs_checked(outputs_checked)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no beat for %0d cycles, %0d outputs still expected", quiet_cycles, pending);
			$display("testbench failed");
			$finish;
		end
	end

	// result side: random stalls, and one long hold-off on request
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(posedge clk);
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_sample(input logic command, input logic signed [SAMPLE_W-1:0] value);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{command: command, sample: value};
		do @(posedge clk); while (!item_ready);
		samples_sent++;
		if (command == CMD_FILL)
			fills_sent++;
	endtask

	task automatic send_random_sample();
		logic                       command;
		logic signed [SAMPLE_W-1:0] value;
		command = ($urandom_range(0, 7) == 0) ? CMD_FILL : CMD_FILTER;
		case ($urandom_range(0, 11))
			0:       value = 16'sh7FFF;
			1:       value = 16'sh8000;
			2:       value = '0;
			3:       value = '1;
			default: value = SAMPLE_W'($urandom);
		endcase
		send_sample(command, value);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic load_coef_plan();
		for (int k = 0; k < NREGS; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= k[CFG_IDX_W-1:0];
			cfg_wdata <= coef_plan[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		coef_sets++;
	endtask

	task automatic plan_random_coefs(input coef_style_e style);
		for (int k = 0; k < NREGS; k++) begin
			case (style)
				PLAN_SMALL: coef_plan[k] = coef_t'($urandom_range(0, 8191) - 4096);
				PLAN_EXTREME: begin
					case ($urandom_range(0, 2))
						0:       coef_plan[k] = 16'sh7FFF;
						1:       coef_plan[k] = 16'sh8000;
						default: coef_plan[k] = '0;
					endcase
				end
				default:    coef_plan[k] = coef_t'($urandom);
			endcase
		end
	endtask

	initial begin
		coef_style_e styles [RANDOM_PHASES];
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		idle_on      = 1'b1;
		hold_req     = 1'b0;
		samples_sent = 0;
		fills_sent   = 0;
		coef_sets    = 0;
		quiet_cycles = 0;
		styles = '{PLAN_FULL, PLAN_SMALL, PLAN_FULL, PLAN_EXTREME, PLAN_SMALL, PLAN_FULL};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset taps are all zero
		send_sample(CMD_FILTER, 16'sh7FFF);
		send_sample(CMD_FILL, 16'sh8000);
		drain();

		// largest weights: clipping both ways
		foreach (coef_plan[k]) coef_plan[k] = 16'sh7FFF;
		load_coef_plan();
		send_sample(CMD_FILL, 16'sh7FFF);
		send_sample(CMD_FILTER, 16'sh8000);
		send_sample(CMD_FILL, 16'sh8000);
		send_sample(CMD_FILTER, 16'sh0000);
		send_sample(CMD_FILTER, 16'sh7FFF);
		drain();

		// most negative weights
		foreach (coef_plan[k]) coef_plan[k] = 16'sh8000;
		load_coef_plan();
		send_sample(CMD_FILL, 16'sh7FFF);
		send_sample(CMD_FILL, 16'sh8000);
		send_sample(CMD_FILTER, 16'sh0001);
		send_sample(CMD_FILTER, 16'shFFFF);
		drain();

		// half-way rounding on tap 0, oldest tap sees the sample seven beats back
		foreach (coef_plan[k]) coef_plan[k] = '0;
		coef_plan[0] = 16'sd1;
		coef_plan[7] = 16'sd16384;
		load_coef_plan();
		send_sample(CMD_FILL, 16'sh0000);
		send_sample(CMD_FILTER, 16'sd8192);
		send_sample(CMD_FILTER, -16'sd8192);
		send_sample(CMD_FILTER, 16'sd24576);
		send_sample(CMD_FILTER, -16'sd24576);
		repeat (4) send_sample(CMD_FILTER, 16'sh0000);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			plan_random_coefs(styles[ph]);
			load_coef_plan();
			if (ph == 2)
				hold_req = 1'b1;
			if (ph == RANDOM_PHASES - 1)
				idle_on = 1'b0;
			repeat (PHASE_ITEMS) send_random_sample();
			drain();
		end

		repeat (10) @(posedge clk);
		$display("%0d samples sent (%0d fill commands) under %0d coefficient sets, %0d outputs checked",
			samples_sent, fills_sent, coef_sets, outputs_checked);
		$display("output side held off for %0d cycles once to back up the pipeline", HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/fhp_pkg.sv
rtl/fhp_front.sv
rtl/fhp_queue.sv
rtl/fhp_back.sv
rtl/fir_filter_with_history_preload.sv
test/fir_output_checker.sv
test/testbench.sv
